FILE: hw/rtl/fca_pkg.sv
// Package: shared types and constants of the cluster chain allocator.
package fca_pkg;

    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_FREE   = 3'd1;
    localparam logic [2:0] ACT_FIND   = 3'd2;
    localparam logic [2:0] ACT_ENSURE = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;
    localparam logic [2:0] ACT_WRITE  = 3'd5;

    localparam logic CFG_DATA_START    = 1'b0;
    localparam logic CFG_CLUSTER_COUNT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input word, cur <= start
        logic cur_from_rd; // cur <= read data
        logic cur_from_scan;
        logic scan_init;   // scan <= effective data start
        logic scan_inc;
        logic rd_cur;      // read entry at cur
        logic rd_scan;     // read entry at scan
        logic rd_addr;     // read entry at entry_address
        logic wr_cur_zero;
        logic wr_scan_end;
        logic wr_cur_scan; // link cur -> scan
        logic wr_addr_val;
        logic pos_dec;
        logic set_first_scan;
        logic set_last_scan;
        logic set_result_cur;
        logic set_result_rd;
        logic set_result_scan;
        logic set_ok;
        logic clr_ok;
        logic out_load;
        logic clear_wr;    // clearing pass write
    } fca_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic cur_zero;
        logic cur_end;
        logic cur_ok;
        logic rd_zero;
        logic rd_end;
        logic scan_ok;
        logic pos_zero;
        logic addr_ok;
        logic clear_last;
    } fca_stat_t;

endpackage

FILE: hw/rtl/fca_ram.sv
// Generic single-port RAM with registered read.
module fca_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hw/rtl/fca_datapath.sv
// Datapath: link table, walk and scan pointers, result registers.
module fca_datapath
    import fca_pkg::*;
#(
    parameter int CLUSTERS   = 4096,
    parameter int LINK_WIDTH = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  fca_cmd_t    cmd,
    output fca_stat_t   stat,
    input  logic [11:0] data_start_cfg,
    input  logic [12:0] cluster_count_cfg,
    input  logic [2:0]  action,
    input  logic [12:0] chain_start,
    input  logic [11:0] chain_position,
    input  logic [12:0] entry_address,
    input  logic [12:0] entry_value,
    output logic        ok,
    output logic [12:0] result_cluster,
    output logic [12:0] head_cluster,
    output logic        last_updated,
    output logic [12:0] tail_cluster
);
    localparam int AW = $clog2(CLUSTERS);
    localparam logic [LINK_WIDTH-1:0] END_MARK = '1;

    logic [2:0]  act_reg;
    logic [12:0] cur_reg, scan_reg, addr_reg, val_reg;
    logic [11:0] pos_reg;
    logic [12:0] first_reg, last_reg, res_reg;
    logic        ok_reg, lupd_reg;
    logic [AW:0] clr_reg;
    logic [16:0] lim;
    logic [LINK_WIDTH-1:0] rd, wdata;
    logic [AW-1:0] ram_addr;
    logic        we;
    logic [12:0] rd13;

    assign lim = ({4'd0, cluster_count_cfg} < 17'(CLUSTERS)) ?
                 {4'd0, cluster_count_cfg} : 17'(CLUSTERS);
    assign rd13 = (LINK_WIDTH >= 13) ? 13'(rd[LINK_WIDTH-1:0]) : 13'(rd);

    always_comb
    begin
        ram_addr = clr_reg[AW-1:0];
        wdata = '0;
        we = cmd.clear_wr;
        if (cmd.rd_cur || cmd.wr_cur_zero || cmd.wr_cur_scan)
        begin
            ram_addr = AW'(cur_reg);
        end
        else if (cmd.rd_scan || cmd.wr_scan_end)
        begin
            ram_addr = AW'(scan_reg);
        end
        else if (cmd.rd_addr || cmd.wr_addr_val)
        begin
            ram_addr = AW'(addr_reg);
        end
        if (cmd.wr_cur_zero)
        begin
            we = 1'b1;
        end
        if (cmd.wr_scan_end)
        begin
            we = 1'b1;
            wdata = END_MARK;
        end
        if (cmd.wr_cur_scan)
        begin
            we = 1'b1;
            wdata = LINK_WIDTH'(scan_reg);
        end
        if (cmd.wr_addr_val)
        begin
            we = 1'b1;
            wdata = LINK_WIDTH'(val_reg);
        end
    end

    fca_ram #(.WIDTH(LINK_WIDTH), .DEPTH(CLUSTERS)) u_ram (
        .clk  (clk),
        .we   (we),
        .addr (ram_addr),
        .wdata(wdata),
        .rdata(rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            cur_reg   <= chain_start;
            pos_reg   <= chain_position;
            addr_reg  <= entry_address;
            val_reg   <= entry_value;
            first_reg <= chain_start;
            last_reg  <= '0;
            lupd_reg  <= 1'b0;
            res_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        if (cmd.cur_from_rd)   cur_reg <= rd13;
        if (cmd.cur_from_scan) cur_reg <= scan_reg;
        if (cmd.scan_init)
            scan_reg <= (data_start_cfg == 12'd0) ? 13'd1 : {1'b0, data_start_cfg};
        if (cmd.scan_inc)      scan_reg <= scan_reg + 13'd1;
        if (cmd.pos_dec)       pos_reg <= pos_reg - 12'd1;
        if (cmd.set_first_scan) first_reg <= scan_reg;
        if (cmd.set_last_scan)
        begin
            last_reg <= scan_reg;
            lupd_reg <= 1'b1;
        end
        if (cmd.set_result_cur)  res_reg <= cur_reg;
        if (cmd.set_result_rd)   res_reg <= rd13;
        if (cmd.set_result_scan) res_reg <= scan_reg;
        if (cmd.set_ok)          ok_reg <= 1'b1;
        if (cmd.clr_ok)          ok_reg <= 1'b0;
        if (cmd.out_load)
        begin
            ok             <= ok_reg;
            result_cluster <= ok_reg ? res_reg : 13'd0;
            head_cluster   <= (act_reg == ACT_ENSURE) ? first_reg : 13'd0;
            last_updated   <= (act_reg == ACT_ENSURE) ? lupd_reg : 1'b0;
            tail_cluster   <= (act_reg == ACT_ENSURE) ? last_reg : 13'd0;
        end
    end

    assign stat.action     = act_reg;
    assign stat.cur_zero   = (cur_reg == 13'd0);
    assign stat.cur_end    = (LINK_WIDTH <= 13) && (cur_reg == 13'(END_MARK));
    assign stat.cur_ok     = {4'd0, cur_reg} < lim;
    assign stat.rd_zero    = (rd == '0);
    assign stat.rd_end     = (rd == END_MARK);
    assign stat.scan_ok    = {4'd0, scan_reg} < lim;
    assign stat.pos_zero   = (pos_reg == 12'd0);
    assign stat.addr_ok    = {4'd0, addr_reg} < lim;
    assign stat.clear_last = (clr_reg == (AW+1)'(CLUSTERS - 1));
endmodule

FILE: hw/rtl/fca_ctrl.sv
// Controller: sequences clearing pass, scans, chain walks and result.
module fca_ctrl
    import fca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  fca_stat_t stat,
    output fca_cmd_t  cmd
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SCANW  = 4'd4;
    localparam logic [3:0] S_FREE   = 4'd5;
    localparam logic [3:0] S_FREEW  = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_WALKW  = 4'd8;
    localparam logic [3:0] S_RAWW   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_LINKSCAN = 4'd11;
    localparam logic [3:0] S_LINKW    = 4'd12;
    localparam logic [3:0] S_LINK     = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       ret_walk_reg, ret_walk_next; // scan belongs to ensure walk
    logic       busy_out_reg, busy_out_next;
    logic       accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = busy_out_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ret_walk_next = ret_walk_reg;
        busy_out_next = busy_out_reg && out_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.action)
                    ACT_ALLOC:
                    begin
                        cmd.scan_init = 1'b1;
                        ret_walk_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    ACT_FREE:
                    begin
                        cmd.set_ok = 1'b1;
                        state_next = S_FREE;
                    end
                    ACT_FIND:
                    begin
                        if (stat.cur_zero) state_next = S_DONE;
                        else
                        begin
                            cmd.set_ok = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    ACT_ENSURE:
                    begin
                        cmd.set_ok = 1'b1;
                        if (stat.cur_zero)
                        begin
                            cmd.scan_init = 1'b1;
                            ret_walk_next = 1'b1;
                            state_next = S_SCAN;
                        end
                        else state_next = S_WALK;
                    end
                    ACT_READ:
                    begin
                        if (stat.addr_ok)
                        begin
                            cmd.rd_addr = 1'b1;
                            state_next = S_RAWW;
                        end
                        else state_next = S_DONE;
                    end
                    ACT_WRITE:
                    begin
                        if (stat.addr_ok)
                        begin
                            cmd.wr_addr_val = 1'b1;
                            cmd.set_ok = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_ok)
                begin
                    cmd.rd_scan = 1'b1;
                    state_next = S_SCANW;
                end
                else
                begin
                    cmd.clr_ok = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SCANW:
            begin
                if (stat.rd_zero)
                begin
                    cmd.wr_scan_end = 1'b1;
                    cmd.set_last_scan = ret_walk_reg || (stat.action == ACT_ENSURE);
                    if (stat.action == ACT_ENSURE)
                    begin
                        cmd.cur_from_scan = 1'b1;
                        if (stat.cur_zero) cmd.set_first_scan = 1'b1;
                        else
                        begin
                            // return to the walk through S_FREEW after the end mark write
                            state_next = S_FREEW;
                        end
                        if (stat.cur_zero) state_next = S_WALK;
                    end
                    else
                    begin
                        cmd.set_ok = 1'b1;
                        cmd.set_result_scan = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_FREE:
            begin
                if (stat.action == ACT_ENSURE)
                begin
                    // unreachable for ensure
                    state_next = S_DONE;
                end
                else if (stat.cur_zero || stat.cur_end) state_next = S_DONE;
                else if (!stat.cur_ok)
                begin
                    cmd.clr_ok = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_FREEW;
                end
            end
            S_FREEW:
            begin
                if (stat.action == ACT_ENSURE)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.wr_cur_zero = 1'b1;
                    cmd.cur_from_rd = 1'b1;
                    state_next = S_FREE;
                end
            end
            S_WALK:
            begin
                if (stat.pos_zero)
                begin
                    cmd.set_result_cur = 1'b1;
                    state_next = S_DONE;
                end
                else if (!stat.cur_ok)
                begin
                    cmd.clr_ok = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_WALKW;
                end
            end
            S_WALKW:
            begin
                if (stat.rd_end)
                begin
                    if (stat.action == ACT_FIND)
                    begin
                        cmd.clr_ok = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        ret_walk_next = 1'b1;
                        state_next = S_LINKSCAN;
                    end
                end
                else
                begin
                    cmd.cur_from_rd = 1'b1;
                    cmd.pos_dec = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_LINKSCAN:
            begin
                if (stat.scan_ok)
                begin
                    cmd.rd_scan = 1'b1;
                    state_next = S_LINKW;
                end
                else
                begin
                    cmd.clr_ok = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_LINKW:
            begin
                if (stat.rd_zero)
                begin
                    cmd.wr_scan_end = 1'b1;
                    cmd.set_last_scan = 1'b1;
                    state_next = S_LINK;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next = S_LINKSCAN;
                end
            end
            S_LINK:
            begin
                cmd.wr_cur_scan = 1'b1;
                cmd.cur_from_scan = 1'b1;
                cmd.pos_dec = 1'b1;
                state_next = S_WALK;
            end
            S_RAWW:
            begin
                cmd.set_ok = 1'b1;
                cmd.set_result_rd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!busy_out_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    busy_out_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ret_walk_reg <= 1'b0;
            busy_out_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_walk_reg <= ret_walk_next;
            busy_out_reg <= busy_out_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DISP))
        else $error("load without dispatch");
endmodule

FILE: hw/rtl/fat_chain_allocator.sv
// Top level: cluster chain allocator over a link table.
//  channel | dir | handshake           | word
//  in      | in  | in_valid/in_stall   | action, chain_start, position, entry fields
//  out     | out | out_valid/out_stall | ok, result, head, last_updated, tail fields
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// Clearing pass after reset writes zero to every table entry, no input taken.
// Scans and walks read the table one entry at a time, and each appended link
// is a separate write (single RAM port, registered read).
// Input stalls until the controller is idle again; a stalled result holds in the
// output register and only delays the load of the next one.
module fat_chain_allocator
    import fca_pkg::*;
#(
    parameter int CLUSTERS   = 4096,
    parameter int LINK_WIDTH = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [12:0] chain_start,
    input  logic [11:0] chain_position,
    input  logic [12:0] entry_address,
    input  logic [12:0] entry_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [12:0] result_cluster,
    output logic [12:0] head_cluster,
    output logic        last_updated,
    output logic [12:0] tail_cluster,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    fca_cmd_t    cmd;
    fca_stat_t   stat;
    logic [11:0] data_start_reg;
    logic [12:0] cluster_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg    <= 12'd1;
            cluster_count_reg <= 13'd4096;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DATA_START:    data_start_reg    <= cfg_data[11:0];
                CFG_CLUSTER_COUNT: cluster_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fca_datapath #(.CLUSTERS(CLUSTERS), .LINK_WIDTH(LINK_WIDTH)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .data_start_cfg   (data_start_reg),
        .cluster_count_cfg(cluster_count_reg),
        .action           (action),
        .chain_start      (chain_start),
        .chain_position   (chain_position),
        .entry_address    (entry_address),
        .entry_value      (entry_value),
        .ok               (ok),
        .result_cluster   (result_cluster),
        .head_cluster     (head_cluster),
        .last_updated     (last_updated),
        .tail_cluster     (tail_cluster)
    );
endmodule
